FILE: rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation core.
// Holds the configuration bus widths and register map; depends on nothing.
`default_nettype none

package mexp_pkg;

	// The configuration port carries 64-bit beats, since both registers exceed 32 bits.
	localparam int unsigned DATA_W = 64;
	localparam int unsigned ADDR_W = 4;

	// Registers lie at 8-byte steps, so this address bit selects the register.
	localparam int unsigned REG_SEL_BIT = 3;

	typedef logic [DATA_W-1:0] apb_data_t;
	typedef logic [ADDR_W-1:0] apb_addr_t;

	typedef enum logic {
		REG_EXPONENT = 1'b0,
		REG_MODULUS  = 1'b1
	} reg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/modular_exponentiation_core.sv
// Modular exponentiation core: power = base ^ exponent mod modulus, bit-serial datapath.
// Depends on mexp_pkg for the configuration bus types and the register map.
//
// Usage:
// The exponent (byte address 0) and the modulus (byte address 8) are written through
// the APB-style port while the core is idle. Each register is OPERAND_WIDTH bits wide
// and reads back zero-extended. After reset the exponent is 0 and the modulus is 1.
// A beat on the input channel (in_valid, in_stall, base) carries one base value. The
// core raises in_stall for as long as it works on that base, so it holds one item at
// a time. The base is first reduced by the modulus one bit per cycle. Then for each
// exponent bit one round runs two shift-and-add modular products side by side: the
// square of the running power of the base, and the product of the accumulator with
// it. Both share one doubling register. A final step moves the result to the output
// register.
// The output channel (out_valid, out_stall, power) is driven from a register. While the
// receiver stalls, the result stays put and the next base is accepted and computed. A
// finished result waits in its final step until the output register is free.
// Reset clears the control state, drops the output valid and restores the configuration registers.
`default_nettype none

module modular_exponentiation_core #(
	parameter int unsigned OPERAND_WIDTH = 56
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// Configuration port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  mexp_pkg::apb_addr_t    paddr,
	input  wire  mexp_pkg::apb_data_t    pwdata,
	output mexp_pkg::apb_data_t          prdata,
	output logic                         pready,
	// Input channel
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [OPERAND_WIDTH-1:0]     base,
	// Output channel
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [OPERAND_WIDTH-1:0]     power
);

	localparam int unsigned W     = OPERAND_WIDTH;
	localparam int unsigned CNT_W = $clog2(W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_REDUCE,
		S_MUL,
		S_DRAIN
	} state_t;

	// (x + y) mod m, valid for x, y < m.
	function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[W-1:0];
	endfunction

	// Configuration registers
	logic [W-1:0] exponent_q;
	logic [W-1:0] modulus_q;

	// Control state
	state_t           state_q;
	logic [CNT_W-1:0] step_q;
	logic [CNT_W-1:0] round_q;
	logic             out_valid_q;

	// Datapath registers
	logic [W-1:0] base_sh_q;   // base, shifted out MSB first during the reduction
	logic [W-1:0] r_q;         // partial remainder of the base
	logic [W-1:0] exp_sh_q;    // exponent, one bit consumed per round
	logic [W-1:0] acc_q;       // running result
	logic [W-1:0] d_q;         // shared multiplicand, doubled mod m on every step but the last of a round
	logic [W-1:0] ba_q;        // multiplier bits of acc * square
	logic [W-1:0] bb_q;        // multiplier bits of square * square
	logic [W-1:0] pa_q;        // partial product acc * square
	logic [W-1:0] pb_q;        // partial product square * square
	logic [W-1:0] power_q;

	logic             cfg_write;
	logic             step_last;
	logic             round_last;
	logic             out_free;
	logic [W:0]       r_trial;
	logic [W-1:0]     r_next;
	logic [W-1:0]     d_next;
	logic [W-1:0]     pa_next;
	logic [W-1:0]     pb_next;
	logic [W-1:0]     acc_init;
	logic [W-1:0]     acc_new;

	// ---------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready is tied high.
	// ---------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q  <= W'(1);
		end else if (cfg_write) begin
			unique case (mexp_pkg::reg_idx_t'(paddr[mexp_pkg::REG_SEL_BIT]))
				mexp_pkg::REG_EXPONENT: exponent_q <= pwdata[W-1:0];
				mexp_pkg::REG_MODULUS:  modulus_q  <= pwdata[W-1:0];
				default:                exponent_q <= exponent_q;
			endcase
		end
	end

	always_comb begin
		unique case (mexp_pkg::reg_idx_t'(paddr[mexp_pkg::REG_SEL_BIT]))
			mexp_pkg::REG_EXPONENT: prdata = mexp_pkg::apb_data_t'(exponent_q);
			mexp_pkg::REG_MODULUS:  prdata = mexp_pkg::apb_data_t'(modulus_q);
			default:                prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Datapath combinational steps.
	// ---------------------------------------------------------------------
	assign step_last  = (step_q == LAST);
	assign round_last = (round_q == LAST);
	assign out_free   = !out_valid_q || !out_stall;

	// Base reduction: shift in the next base bit and subtract the modulus once if needed.
	// The remainder stays below the modulus, so one compare and subtract suffices.
	assign r_trial = {r_q, base_sh_q[W-1]};
	assign r_next  = (r_trial >= {1'b0, modulus_q}) ? W'(r_trial - {1'b0, modulus_q})
	                                                : r_trial[W-1:0];

	// Both products multiply the same square, so a single doubling register serves both.
	assign d_next  = add_mod(d_q, d_q, modulus_q);
	assign pa_next = ba_q[0] ? add_mod(pa_q, d_q, modulus_q) : pa_q;
	assign pb_next = bb_q[0] ? add_mod(pb_q, d_q, modulus_q) : pb_q;

	assign acc_init = (modulus_q == W'(1)) ? '0 : W'(1);
	assign acc_new  = exp_sh_q[0] ? pa_next : acc_q;

	// ---------------------------------------------------------------------
	// Sequencer: state, counters and the output valid.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result takes the output register as the old one leaves it.
			if (state_q == S_DRAIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_REDUCE;
						step_q  <= '0;
					end
				end
				S_REDUCE: begin
					if (step_last) begin
						state_q <= S_MUL;
						step_q  <= '0;
						round_q <= '0;
					end else begin
						step_q <= step_q + CNT_W'(1);
					end
				end
				S_MUL: begin
					if (step_last) begin
						step_q <= '0;
						if (round_last) begin
							state_q <= S_DRAIN;
						end else begin
							round_q <= round_q + CNT_W'(1);
						end
					end else begin
						step_q <= step_q + CNT_W'(1);
					end
				end
				S_DRAIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Datapath registers. No reset: every value is loaded before it is used.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					base_sh_q <= base;
					r_q       <= '0;
					exp_sh_q  <= exponent_q;
				end
			end
			S_REDUCE: begin
				base_sh_q <= base_sh_q << 1;
				r_q       <= r_next;
				if (step_last) begin
					// The reduced base is the first square; start round zero.
					d_q   <= r_next;
					bb_q  <= r_next;
					acc_q <= acc_init;
					ba_q  <= acc_init;
					pa_q  <= '0;
					pb_q  <= '0;
				end
			end
			S_MUL: begin
				if (step_last) begin
					// Round done: keep the product where the exponent bit is set, and
					// restart both products on the new square.
					acc_q    <= acc_new;
					ba_q     <= acc_new;
					d_q      <= pb_next;
					bb_q     <= pb_next;
					pa_q     <= '0;
					pb_q     <= '0;
					exp_sh_q <= exp_sh_q >> 1;
				end else begin
					d_q  <= d_next;
					pa_q <= pa_next;
					pb_q <= pb_next;
					ba_q <= ba_q >> 1;
					bb_q <= bb_q >> 1;
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					power_q <= (modulus_q == '0) ? '0 : acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign power     = power_q;

`ifndef ASSERT_OFF
	// An accepted beat starts the reduction from its first bit.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_REDUCE && step_q == '0)
		else $error("accepted base did not start the reduction");

	// A result appears only when the final step hands it over.
	a_valid_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DRAIN)
		else $error("output valid rose outside the final step");

	// Each round starts both partial products from zero.
	a_round_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL && step_q == '0 |-> pa_q == '0 && pb_q == '0)
		else $error("partial products not cleared at round start");

	// The squaring multiplier and the shared multiplicand start from the same square.
	a_square_operands: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL && step_q == '0 |-> bb_q == d_q)
		else $error("square operands differ at round start");
`endif

endmodule

`default_nettype wire
